// ----- hdl/inode_block_map_walker_unit_macros.svh -----
// Assertion macros for the block map walker.
// Used by the walker and top-level modules; no other dependencies.
`ifndef INODE_BLOCK_MAP_WALKER_UNIT_MACROS_SVH
`define INODE_BLOCK_MAP_WALKER_UNIT_MACROS_SVH
`ifndef SYNTH
// Checked property, ignored while reset is high
`define IMBW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("imbw assertion failed");
// Checked property, also checked during reset
`define IMBW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("imbw assertion failed");
`else
`define IMBW_ASSERT(lbl, clk, rst, prop)
`define IMBW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hdl/imbw_pkg.sv -----
// Types and constants shared by the block map walker modules.
// No dependencies.
package imbw_pkg;

  localparam int PTR_W  = 32;
  localparam int WORD_W = 14;
  localparam int REM_W  = 28;
  localparam int LBS_W  = 3;

  localparam logic [LBS_W-1:0] LBS_RESET = 3'd2;
  localparam logic [LBS_W-1:0] LBS_MAX   = 3'd6;
  localparam logic [3:0]       BASE_K    = 4'd8;

  // Item kind codes
  localparam logic [1:0] KIND_LOAD     = 2'd0;
  localparam logic [1:0] KIND_LOOKUP   = 2'd1;
  localparam logic [1:0] KIND_RESPONSE = 2'd2;

  // Result kind codes
  localparam logic RK_REQUEST = 1'b0;
  localparam logic RK_ANSWER  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_RDERR  = 2'd2;
  localparam logic [1:0] ST_BUSY   = 2'd3;

  // Indirect levels below the pending read
  localparam logic [1:0] LV_NONE   = 2'd0;
  localparam logic [1:0] LV_ONE    = 2'd1;
  localparam logic [1:0] LV_TWO    = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       slot;
    logic [PTR_W-1:0] value;
    logic [PTR_W-1:0] logical_block;
    logic             read_failed;
  } item_t;

  typedef struct packed {
    logic              result_kind;
    logic [PTR_W-1:0]  block_number;
    logic [WORD_W-1:0] word_index;
    logic [1:0]        status;
  } result_t;

  // Per-beat control from the top level to the walker
  typedef struct packed {
    logic             step;
    logic [LBS_W-1:0] log_block_size;
  } walk_ctl_t;

  // Pointer slot write
  typedef struct packed {
    logic             en;
    logic [3:0]       slot;
    logic [PTR_W-1:0] data;
  } slot_wr_t;

endpackage

// ----- hdl/imbw_slots.sv -----
// Pointer slot register file: direct, single, double and triple pointers.
// Depends on imbw_pkg.
module imbw_slots #(
  parameter int DIRECT_SLOTS = 12
) (
  input  logic                              clk,
  input  imbw_pkg::slot_wr_t                wr,
  input  logic [$clog2(DIRECT_SLOTS+3)-1:0] rd_addr,
  output logic [imbw_pkg::PTR_W-1:0]        rd_data
);

  localparam int SLOT_COUNT = DIRECT_SLOTS + 3;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);

  logic [imbw_pkg::PTR_W-1:0] slots [SLOT_COUNT];

  // Write a loaded pointer; drop loads beyond the last slot
  always_ff @(posedge clk) begin
    if (wr.en && (wr.slot < 4'(SLOT_COUNT))) begin
      slots[wr.slot[SLOT_AW-1:0]] <= wr.data;
    end
  end

  // Read one slot; compare one bit wider so the slot count always fits
  assign rd_data = ({1'b0, rd_addr} < (SLOT_AW+1)'(SLOT_COUNT)) ? slots[rd_addr] : '0;

endmodule

// ----- hdl/imbw_walker.sv -----
// Lookup decode and indirect walk state; produces at most one result per beat.
// Depends on imbw_pkg and the assertion macro header.
`include "inode_block_map_walker_unit_macros.svh"
module imbw_walker #(
  parameter int DIRECT_SLOTS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  imbw_pkg::walk_ctl_t               ctl,
  input  imbw_pkg::item_t                   item,
  output logic [$clog2(DIRECT_SLOTS+3)-1:0] rd_addr,
  input  logic [imbw_pkg::PTR_W-1:0]        rd_data,
  output logic                              res_valid,
  output imbw_pkg::result_t                 res
);

  localparam int SLOT_AW = $clog2(DIRECT_SLOTS + 3);
  localparam logic [SLOT_AW-1:0] SINGLE_SLOT = SLOT_AW'(DIRECT_SLOTS);
  localparam logic [SLOT_AW-1:0] DOUBLE_SLOT = SLOT_AW'(DIRECT_SLOTS + 1);
  localparam logic [SLOT_AW-1:0] TRIPLE_SLOT = SLOT_AW'(DIRECT_SLOTS + 2);

  logic                       busy, busy_next;
  logic [1:0]                 levels, levels_next;
  logic [imbw_pkg::REM_W-1:0] rem, rem_next;

  logic [imbw_pkg::LBS_W-1:0] lbs_eff;
  logic [3:0]                 k;
  logic [4:0]                 k2;
  logic [5:0]                 k3;
  logic [imbw_pkg::REM_W-1:0] mask1, mask2;
  logic [imbw_pkg::PTR_W-1:0] n, n1, n2, n3;
  logic [imbw_pkg::PTR_W-1:0] idx2, idx3;
  logic [imbw_pkg::REM_W-1:0] rem_hi;
  logic                       is_direct, in_single, in_double, in_triple;

  // Index bits per level; codes above the largest size count as the largest
  assign lbs_eff = (ctl.log_block_size > imbw_pkg::LBS_MAX) ?
                   imbw_pkg::LBS_MAX : ctl.log_block_size;
  assign k     = imbw_pkg::BASE_K + {1'b0, lbs_eff};
  assign k2    = {k, 1'b0};
  assign k3    = {1'b0, k2} + {2'b00, k};
  assign mask1 = (imbw_pkg::REM_W'(1) << k) - imbw_pkg::REM_W'(1);
  assign mask2 = (imbw_pkg::REM_W'(1) << k2) - imbw_pkg::REM_W'(1);

  // Range split of the logical block, compared exactly
  assign n         = item.logical_block;
  assign is_direct = n < imbw_pkg::PTR_W'(DIRECT_SLOTS);
  assign n1        = n - imbw_pkg::PTR_W'(DIRECT_SLOTS);
  assign in_single = (n1 >> k) == '0;
  assign n2        = n1 - (imbw_pkg::PTR_W'(1) << k);
  assign in_double = (n2 >> k2) == '0;
  assign n3        = n2 - (imbw_pkg::PTR_W'(1) << k2);
  assign in_triple = (n3 >> k3) == '0;
  assign idx2      = n2 >> k;
  assign idx3      = n3 >> k2;
  assign rem_hi    = rem >> k;

  // Decode one item into a result and the next walk state
  always_comb begin
    res_valid   = 1'b0;
    res         = '0;
    busy_next   = busy;
    levels_next = levels;
    rem_next    = rem;
    rd_addr     = n[SLOT_AW-1:0];
    unique case (item.kind)
      imbw_pkg::KIND_LOOKUP: begin
        res_valid = 1'b1;
        res.result_kind = imbw_pkg::RK_ANSWER;
        if (busy) begin
          res.status = imbw_pkg::ST_BUSY;
        end else if (is_direct) begin
          res.block_number = rd_data;
        end else if (in_single) begin
          rd_addr          = SINGLE_SLOT;
          res.result_kind  = imbw_pkg::RK_REQUEST;
          res.block_number = rd_data;
          res.word_index   = n1[imbw_pkg::WORD_W-1:0];
          busy_next        = 1'b1;
          levels_next      = imbw_pkg::LV_NONE;
          rem_next         = '0;
        end else if (in_double) begin
          rd_addr          = DOUBLE_SLOT;
          res.result_kind  = imbw_pkg::RK_REQUEST;
          res.block_number = rd_data;
          res.word_index   = idx2[imbw_pkg::WORD_W-1:0];
          busy_next        = 1'b1;
          levels_next      = imbw_pkg::LV_ONE;
          rem_next         = n2[imbw_pkg::REM_W-1:0] & mask1;
        end else if (in_triple) begin
          rd_addr          = TRIPLE_SLOT;
          res.result_kind  = imbw_pkg::RK_REQUEST;
          res.block_number = rd_data;
          res.word_index   = idx3[imbw_pkg::WORD_W-1:0];
          busy_next        = 1'b1;
          levels_next      = imbw_pkg::LV_TWO;
          rem_next         = n3[imbw_pkg::REM_W-1:0] & mask2;
        end else begin
          res.status = imbw_pkg::ST_RANGE;
        end
      end
      imbw_pkg::KIND_RESPONSE: begin
        if (busy) begin
          res_valid = 1'b1;
          if (item.read_failed || (levels == imbw_pkg::LV_NONE)) begin
            // End the walk with the final answer or a read error
            res.result_kind  = imbw_pkg::RK_ANSWER;
            res.block_number = item.read_failed ? '0 : item.value;
            res.status       = item.read_failed ? imbw_pkg::ST_RDERR : imbw_pkg::ST_OK;
            busy_next        = 1'b0;
            levels_next      = imbw_pkg::LV_NONE;
            rem_next         = '0;
          end else begin
            // Descend one level and request the next pointer
            res.result_kind  = imbw_pkg::RK_REQUEST;
            res.block_number = item.value;
            if (levels == imbw_pkg::LV_TWO) begin
              res.word_index = rem_hi[imbw_pkg::WORD_W-1:0];
              levels_next    = imbw_pkg::LV_ONE;
              rem_next       = rem & mask1;
            end else begin
              res.word_index = rem[imbw_pkg::WORD_W-1:0];
              levels_next    = imbw_pkg::LV_NONE;
              rem_next       = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Advance the walk state once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      levels <= imbw_pkg::LV_NONE;
      rem    <= '0;
    end else if (ctl.step) begin
      busy   <= busy_next;
      levels <= levels_next;
      rem    <= rem_next;
    end
  end

  `IMBW_ASSERT(a_idle_no_levels, clk, rst, !busy |-> (levels == imbw_pkg::LV_NONE) && (rem == '0))
  `IMBW_ASSERT(a_fail_ends_walk, clk, rst, ctl.step && (item.kind == imbw_pkg::KIND_RESPONSE) && item.read_failed |=> !busy)
  `IMBW_ASSERT(a_reject_keeps_walk, clk, rst, ctl.step && (item.kind == imbw_pkg::KIND_LOOKUP) && busy |=> busy && (levels == $past(levels)) && (rem == $past(rem)))

endmodule

// ----- hdl/imbw_outreg.sv -----
// Result register between the walker and the result channel.
// Depends on imbw_pkg.
module imbw_outreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  imbw_pkg::result_t d,
  input  logic              stall,
  output logic              room,
  output logic              valid,
  output imbw_pkg::result_t q
);

  // Free when empty or when the held beat leaves this cycle
  assign room = !valid || !stall;

  // Hold the valid flag until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

// ----- hdl/inode_block_map_walker_unit.sv -----
// Block map walker: translates a file's logical block into a physical block.
// Depends on imbw_pkg, imbw_slots, imbw_walker, imbw_outreg and the macro header.
// One item is accepted per clock cycle while the result side keeps up; each
// item is held in the input register and its result, if any, is then loaded
// into the result register. A lookup in the direct range answers from the
// slot registers; an indirect lookup issues one read request and then one
// more for each further indirect level as each response item arrives, so its
// total time is set by the round trips of the memory that serves those reads.
// The pointer slots have no reset and must be loaded before a lookup reads them.
// The configuration port is always ready and takes effect on the next item.
`include "inode_block_map_walker_unit_macros.svh"
module inode_block_map_walker_unit #(
  parameter int DIRECT_SLOTS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  imbw_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output imbw_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [imbw_pkg::LBS_W-1:0]       cfg_data
);

  localparam int SLOT_AW = $clog2(DIRECT_SLOTS + 3);

  logic                       s1_valid;
  imbw_pkg::item_t            s1_item;
  logic                       s1_adv;
  logic [imbw_pkg::LBS_W-1:0] log_block_size;
  imbw_pkg::walk_ctl_t        ctl;
  imbw_pkg::slot_wr_t         slot_wr;
  logic [SLOT_AW-1:0]         rd_addr;
  logic [imbw_pkg::PTR_W-1:0] rd_data;
  logic                       res_valid;
  imbw_pkg::result_t          res;
  logic                       room;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      log_block_size <= imbw_pkg::LBS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      log_block_size <= cfg_data;
    end
  end

  // Move the held item on unless its result has nowhere to go
  assign s1_adv     = s1_valid && (!res_valid || room);
  assign item_stall = s1_valid && !s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  assign ctl.step           = s1_adv;
  assign ctl.log_block_size = log_block_size;

  assign slot_wr.en   = s1_adv && (s1_item.kind == imbw_pkg::KIND_LOAD);
  assign slot_wr.slot = s1_item.slot;
  assign slot_wr.data = s1_item.value;

  imbw_slots #(
    .DIRECT_SLOTS(DIRECT_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr      (slot_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  imbw_walker #(
    .DIRECT_SLOTS(DIRECT_SLOTS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .item      (s1_item),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res)
  );

  imbw_outreg u_outreg (
    .clk   (clk),
    .rst   (rst),
    .load  (s1_adv && res_valid),
    .d     (res),
    .stall (result_stall),
    .room  (room),
    .valid (result_valid),
    .q     (result)
  );

  `IMBW_ASSERT_ALWAYS(a_stall_needs_item, clk, item_stall |-> s1_valid)

endmodule
